### src/wbsp_pkg.sv
// shared types, codes and constants for the log batch parser
package wbsp_pkg;

   localparam int unsigned MAX_VARINT_BYTES = 10;

   typedef enum logic [3:0] {
      PH_VERSION,
      PH_KIND,
      PH_XIDLEN,
      PH_XID,
      PH_COUNT,
      PH_FLAGS,
      PH_CF,
      PH_SEQ,
      PH_KEYLEN,
      PH_VALLEN,
      PH_TTL,
      PH_VLOG,
      PH_KEY,
      PH_VALUE,
      PH_DONE,
      PH_ERROR
   } phase_type;

   // byte roles
   localparam logic [3:0] ROLE_VERSION   = 4'd0;
   localparam logic [3:0] ROLE_KIND      = 4'd1;
   localparam logic [3:0] ROLE_HDR_VINT  = 4'd2;
   localparam logic [3:0] ROLE_XID       = 4'd3;
   localparam logic [3:0] ROLE_FLAGS     = 4'd4;
   localparam logic [3:0] ROLE_ENT_VINT  = 4'd5;
   localparam logic [3:0] ROLE_KEY       = 4'd6;
   localparam logic [3:0] ROLE_VALUE     = 4'd7;
   localparam logic [3:0] ROLE_TRAILING  = 4'd8;
   localparam logic [3:0] ROLE_DISCARDED = 4'd9;

   // field ids
   localparam logic [3:0] FLD_NONE    = 4'd0;
   localparam logic [3:0] FLD_KIND    = 4'd1;
   localparam logic [3:0] FLD_XIDLEN  = 4'd2;
   localparam logic [3:0] FLD_COUNT   = 4'd3;
   localparam logic [3:0] FLD_FLAGS   = 4'd4;
   localparam logic [3:0] FLD_CF      = 4'd5;
   localparam logic [3:0] FLD_SEQ     = 4'd6;
   localparam logic [3:0] FLD_KEYLEN  = 4'd7;
   localparam logic [3:0] FLD_VALLEN  = 4'd8;
   localparam logic [3:0] FLD_TTL     = 4'd9;
   localparam logic [3:0] FLD_VLOG_ID = 4'd10;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_VERSION = 3'd1;
   localparam logic [2:0] ST_TRUNCATED   = 3'd2;
   localparam logic [2:0] ST_ZERO_VLOG   = 3'd3;
   localparam logic [2:0] ST_VINT_LONG   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [1:0] CSR_TTL_FLAG_MASK    = 2'd1;
   localparam logic [1:0] CSR_VLOG_FLAG_MASK   = 2'd2;

   localparam logic [7:0] EXPECTED_VERSION_RST = 8'd1;
   localparam logic [7:0] TTL_FLAG_MASK_RST    = 8'd1;
   localparam logic [7:0] VLOG_FLAG_MASK_RST   = 8'd2;

   typedef struct packed {
      logic [7:0] expected_version;
      logic [7:0] ttl_flag_mask;
      logic [7:0] vlog_flag_mask;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [63:0] vint_acc;
      logic [3:0]  vint_cnt;
      logic [7:0]  entry_flags;
      logic [63:0] entries_left;
      logic [63:0] bytes_left;
      logic [63:0] held_val_len;
      logic [2:0]  error_code;
   } parse_state_type;

   localparam parse_state_type STATE_RST = '{
      phase:        PH_VERSION,
      vint_acc:     64'd0,
      vint_cnt:     4'd0,
      entry_flags:  8'd0,
      entries_left: 64'd0,
      bytes_left:   64'd0,
      held_val_len: 64'd0,
      error_code:   ST_OK
   };

   typedef struct packed {
      logic [3:0]  byte_role;
      logic [3:0]  field_id;
      logic [63:0] field_value;
      logic [7:0]  byte_out;
      logic        entry_done;
      logic        batch_done;
      logic [2:0]  status;
      logic        end_of_buffer;
   } result_type;

endpackage

### src/wal_batch_stream_parser.sv
// top level of the byte-serial log batch parser
//
// usage
// - requests carry one byte of a log batch (req_data_byte) and a flag for the
//   final byte of the buffer (req_last_byte); a request is taken on a clock
//   edge with req_valid high and req_stall low
// - every request gives exactly one response on the rsp_ channel: the byte's
//   role, any field it completes with its value, pass-through data for xid,
//   key and value bytes, entry and batch completion, and a status code
// - the response is valid in the cycle after its request is taken;
//   throughput is one byte per cycle unless rsp_stall holds it, set by
//   the single parse step between the state and response registers
// - while the receiver stalls, the response register holds and req_stall is
//   raised, so the next request waits; a request is taken in the same cycle
//   the pending response leaves
// - the csr_ port writes expected_version, ttl_flag_mask and vlog_flag_mask;
//   write it only while no request is in flight
// - reset restores the registers to 1, 1 and 2, clears the parser to expect
//   a version byte and empties the response register
// - after the final byte of a buffer the parser restarts at the version byte
module wal_batch_stream_parser (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_byte_role,
   output logic [3:0]  rsp_field_id,
   output logic [63:0] rsp_field_value,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_entry_done,
   output logic        rsp_batch_done,
   output logic [2:0]  rsp_status,
   output logic        rsp_end_of_buffer,
   // register write port
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import wbsp_pkg::*;

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      rsp_ff;
   result_type      step_res;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            req_fire;

   // stall only while a response is held and the receiver is not taking it
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   // register writes, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_EXPECTED_VERSION: cfg_in.expected_version = csr_wdata;
            CSR_TTL_FLAG_MASK:    cfg_in.ttl_flag_mask    = csr_wdata;
            CSR_VLOG_FLAG_MASK:   cfg_in.vlog_flag_mask   = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{
            expected_version: EXPECTED_VERSION_RST,
            ttl_flag_mask:    TTL_FLAG_MASK_RST,
            vlog_flag_mask:   VLOG_FLAG_MASK_RST
         };
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // one parse step per byte
   wbsp_step u_step (
      .cur       (state_ff),
      .cfg       (cfg_ff),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .nxt       (state_in),
      .res       (step_res)
   );

   // parser state advances only on a taken request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RST;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // response register: loads on a taken request, holds while stalled
   assign rsp_valid_in = req_fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_role     = rsp_ff.byte_role;
   assign rsp_field_id      = rsp_ff.field_id;
   assign rsp_field_value   = rsp_ff.field_value;
   assign rsp_byte_out      = rsp_ff.byte_out;
   assign rsp_entry_done    = rsp_ff.entry_done;
   assign rsp_batch_done    = rsp_ff.batch_done;
   assign rsp_status        = rsp_ff.status;
   assign rsp_end_of_buffer = rsp_ff.end_of_buffer;

   // a buffer's final byte always returns the parser to the version byte
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last_byte |=> state_ff.phase == PH_VERSION)
      else $error("parser did not restart after end of buffer");

   // trailing bytes never carry an error
   a_trailing_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_role == ROLE_TRAILING) |-> rsp_status == ST_OK)
      else $error("trailing byte reported an error");

   // a batch completing without an entry can only come from a zero count
   a_batch_without_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_batch_done && !rsp_entry_done |-> rsp_field_id == FLD_COUNT)
      else $error("batch completion without entry or count");

   // data pass-through only on xid, key and value bytes
   a_byte_out_roles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_out != 8'd0) |->
         (rsp_byte_role == ROLE_XID) || (rsp_byte_role == ROLE_KEY) ||
         (rsp_byte_role == ROLE_VALUE))
      else $error("data byte passed through on a non-data role");

   // while the error state is held, the latched code is never ok
   a_error_latched: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_ERROR |-> state_ff.error_code != ST_OK)
      else $error("error phase without a latched error code");

endmodule

### src/wbsp_step.sv
// one parse step: current state and one byte in, next state and result out
module wbsp_step (
   input  wbsp_pkg::parse_state_type cur,
   input  wbsp_pkg::cfg_type         cfg,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   output wbsp_pkg::parse_state_type nxt,
   output wbsp_pkg::result_type      res
);
   import wbsp_pkg::*;

   logic        in_vint;
   logic [5:0]  shift;
   logic [63:0] acc_new;
   logic [3:0]  cnt_inc;
   logic        vint_done;
   logic        vint_long;
   logic        go_key;
   logic        go_value;
   logic        go_complete;

   // byte count never passes nine, so the shift stays within 63
   assign shift      = 6'(cur.vint_cnt) * 6'd7;
   assign acc_new    = cur.vint_acc | (64'(data_byte[6:0]) << shift);
   assign cnt_inc    = cur.vint_cnt + 4'd1;
   assign vint_done  = ~data_byte[7];
   assign vint_long  = data_byte[7] && (cnt_inc >= 4'(MAX_VARINT_BYTES));
   assign in_vint    = cur.phase inside {PH_XIDLEN, PH_COUNT, [PH_CF:PH_VLOG]};

   always_comb begin
      nxt         = cur;
      res         = '0;
      go_key      = 1'b0;
      go_value    = 1'b0;
      go_complete = 1'b0;
      res.end_of_buffer = last_byte;

      // varint accumulate, shared by every varint phase
      if (in_vint) begin
         if (vint_done || vint_long) begin
            nxt.vint_acc = 64'd0;
            nxt.vint_cnt = 4'd0;
         end else begin
            nxt.vint_acc = acc_new;
            nxt.vint_cnt = cnt_inc;
         end
         if (vint_long) begin
            res.status     = ST_VINT_LONG;
            nxt.error_code = ST_VINT_LONG;
            nxt.phase      = PH_ERROR;
         end
      end

      case (cur.phase)
         PH_VERSION: begin
            res.byte_role = ROLE_VERSION;
            if (data_byte != cfg.expected_version) begin
               res.status     = ST_BAD_VERSION;
               nxt.error_code = ST_BAD_VERSION;
               nxt.phase      = PH_ERROR;
            end else begin
               nxt.phase = PH_KIND;
            end
         end
         PH_KIND: begin
            res.byte_role   = ROLE_KIND;
            res.field_id    = FLD_KIND;
            res.field_value = 64'(data_byte);
            nxt.phase       = PH_XIDLEN;
         end
         PH_XIDLEN: begin
            res.byte_role = ROLE_HDR_VINT;
            if (vint_done) begin
               res.field_id    = FLD_XIDLEN;
               res.field_value = acc_new;
               nxt.bytes_left  = acc_new;
               nxt.phase       = (acc_new != 64'd0) ? PH_XID : PH_COUNT;
            end
         end
         PH_XID: begin
            res.byte_role  = ROLE_XID;
            res.byte_out   = data_byte;
            nxt.bytes_left = cur.bytes_left - 64'd1;
            if (cur.bytes_left == 64'd1) begin
               nxt.phase = PH_COUNT;
            end
         end
         PH_COUNT: begin
            res.byte_role = ROLE_HDR_VINT;
            if (vint_done) begin
               res.field_id     = FLD_COUNT;
               res.field_value  = acc_new;
               nxt.entries_left = acc_new;
               if (acc_new == 64'd0) begin
                  res.batch_done = 1'b1;
                  nxt.phase      = PH_DONE;
               end else begin
                  nxt.phase = PH_FLAGS;
               end
            end
         end
         PH_FLAGS: begin
            res.byte_role   = ROLE_FLAGS;
            res.field_id    = FLD_FLAGS;
            res.field_value = 64'(data_byte);
            nxt.entry_flags = data_byte;
            nxt.phase       = PH_CF;
         end
         PH_CF: begin
            res.byte_role = ROLE_ENT_VINT;
            if (vint_done) begin
               res.field_id    = FLD_CF;
               res.field_value = {32'd0, acc_new[31:0]};
               nxt.phase       = PH_SEQ;
            end
         end
         PH_SEQ: begin
            res.byte_role = ROLE_ENT_VINT;
            if (vint_done) begin
               res.field_id    = FLD_SEQ;
               res.field_value = acc_new;
               nxt.phase       = PH_KEYLEN;
            end
         end
         PH_KEYLEN: begin
            res.byte_role = ROLE_ENT_VINT;
            if (vint_done) begin
               res.field_id    = FLD_KEYLEN;
               res.field_value = acc_new;
               nxt.bytes_left  = acc_new;
               nxt.phase       = PH_VALLEN;
            end
         end
         PH_VALLEN: begin
            res.byte_role = ROLE_ENT_VINT;
            if (vint_done) begin
               res.field_id     = FLD_VALLEN;
               res.field_value  = acc_new;
               nxt.held_val_len = acc_new;
               if ((cur.entry_flags & cfg.ttl_flag_mask) != 8'd0) begin
                  nxt.phase = PH_TTL;
               end else if ((cur.entry_flags & cfg.vlog_flag_mask) != 8'd0) begin
                  nxt.phase = PH_VLOG;
               end else begin
                  go_key = 1'b1;
               end
            end
         end
         PH_TTL: begin
            res.byte_role = ROLE_ENT_VINT;
            if (vint_done) begin
               res.field_id    = FLD_TTL;
               res.field_value = acc_new;
               if ((cur.entry_flags & cfg.vlog_flag_mask) != 8'd0) begin
                  nxt.phase = PH_VLOG;
               end else begin
                  go_key = 1'b1;
               end
            end
         end
         PH_VLOG: begin
            res.byte_role = ROLE_ENT_VINT;
            if (vint_done) begin
               res.field_id    = FLD_VLOG_ID;
               res.field_value = acc_new;
               if (acc_new == 64'd0) begin
                  res.status     = ST_ZERO_VLOG;
                  nxt.error_code = ST_ZERO_VLOG;
                  nxt.phase      = PH_ERROR;
               end else begin
                  go_key = 1'b1;
               end
            end
         end
         PH_KEY: begin
            res.byte_role  = ROLE_KEY;
            res.byte_out   = data_byte;
            nxt.bytes_left = cur.bytes_left - 64'd1;
            if (cur.bytes_left == 64'd1) begin
               go_value = 1'b1;
            end
         end
         PH_VALUE: begin
            res.byte_role  = ROLE_VALUE;
            res.byte_out   = data_byte;
            nxt.bytes_left = cur.bytes_left - 64'd1;
            if (cur.bytes_left == 64'd1) begin
               go_complete = 1'b1;
            end
         end
         PH_DONE: begin
            res.byte_role = ROLE_TRAILING;
         end
         default: begin
            res.byte_role = ROLE_DISCARDED;
            res.status    = cur.error_code;
         end
      endcase

      // key, then value, then entry completion
      if (go_key) begin
         if (nxt.bytes_left != 64'd0) begin
            nxt.phase = PH_KEY;
         end else begin
            go_value = 1'b1;
         end
      end
      if (go_value) begin
         if (((nxt.entry_flags & cfg.vlog_flag_mask) == 8'd0) &&
             (nxt.held_val_len != 64'd0)) begin
            nxt.bytes_left = nxt.held_val_len;
            nxt.phase      = PH_VALUE;
         end else begin
            go_complete = 1'b1;
         end
      end
      if (go_complete) begin
         res.entry_done   = 1'b1;
         nxt.entries_left = cur.entries_left - 64'd1;
         if (cur.entries_left == 64'd1) begin
            res.batch_done = 1'b1;
            nxt.phase      = PH_DONE;
         end else begin
            nxt.phase = PH_FLAGS;
         end
      end

      // end of buffer: flag an unfinished batch, restart parsing
      if (last_byte) begin
         if ((res.status == ST_OK) && (nxt.phase != PH_DONE) &&
             (nxt.phase != PH_ERROR)) begin
            res.status = ST_TRUNCATED;
         end
         nxt = STATE_RST;
      end
   end

endmodule
